// File: rtl/tea_pkg.sv
// shared types and constants for the tea block cipher
package tea_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

  // one 64-bit block with its end-of-buffer flag
  typedef struct packed {
    logic        last_block;
    logic [31:0] second_word;
    logic [31:0] first_word;
  } blk_t;

  // 128-bit key as four words
  typedef struct packed {
    logic [31:0] k3;
    logic [31:0] k2;
    logic [31:0] k1;
    logic [31:0] k0;
  } key_t;

  // register word index on the apb port
  typedef enum logic [2:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_MODE = 3'd4
  } reg_idx_t;

endpackage

// File: rtl/tea_block_cipher.sv
// top level of the tea block cipher: apb registers, round pipeline, output skid
// path: each block passes through every half-round stage, then the output register
// throughput: one block per cycle while in_tready is high, one registered half round per pipeline stage
// in_tready drops only when the output register and its skid entry are both full
// reset: synchronous active-low rst_n clears stage valid bits, key words and mode
// to zero; the pipeline is usable in the first cycle after reset
module tea_block_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] first_word, [63:32] second_word
  input  logic        in_tlast,   // last_block
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] out_first_word, [63:32] out_second_word
  output logic        out_tlast,  // out_last_block
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tea_pkg::*;

  // two half rounds per round, each one register stage
  localparam int unsigned NSTAGE = 2 * ROUNDS;

  // configuration registers
  key_t key_r;
  logic mode_r;
  logic cfg_wr;

  // pipeline wiring: entry s feeds stage s, entry s+1 is its register
  logic stg_valid [0:NSTAGE];
  blk_t stg_blk   [0:NSTAGE];
  logic pipe_en;
  logic skid_full;
  blk_t res_blk;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      mode_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_KEY0: key_r.k0 <= cfg_pwdata;
        REG_KEY1: key_r.k1 <= cfg_pwdata;
        REG_KEY2: key_r.k2 <= cfg_pwdata;
        REG_KEY3: key_r.k3 <= cfg_pwdata;
        REG_MODE: mode_r   <= cfg_pwdata[0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_KEY0: cfg_prdata = key_r.k0;
      REG_KEY1: cfg_prdata = key_r.k1;
      REG_KEY2: cfg_prdata = key_r.k2;
      REG_KEY3: cfg_prdata = key_r.k3;
      REG_MODE: cfg_prdata = {31'd0, mode_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // ---------------- round pipeline ----------------
  // whole pipeline moves together; it holds only when the skid entry is taken,
  // and then the skid entry had room for whatever the last stage delivered
  assign pipe_en   = ~skid_full;
  assign in_tready = pipe_en;

  assign stg_valid[0]           = in_tvalid;
  assign stg_blk[0].first_word  = in_tdata[31:0];
  assign stg_blk[0].second_word = in_tdata[63:32];
  assign stg_blk[0].last_block  = in_tlast;

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    // round sums are fixed per stage: enciphering counts up from delta,
    // deciphering counts down from delta times the round count
    localparam int unsigned RND   = s / 2;
    localparam logic [63:0] ENC_P = 64'(TEA_DELTA) * 64'(RND + 1);
    localparam logic [63:0] DEC_P = 64'(TEA_DELTA) * 64'(ROUNDS - RND);

    tea_half_stage u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (pipe_en),
      .second_half (1'((s % 2))),
      .decrypt     (mode_r),
      .key         (key_r),
      .enc_sum     (ENC_P[31:0]),
      .dec_sum     (DEC_P[31:0]),
      .in_valid    (stg_valid[s]),
      .in_blk      (stg_blk[s]),
      .out_valid   (stg_valid[s+1]),
      .out_blk     (stg_blk[s+1])
    );
  end

  // ---------------- output register and skid ----------------
  tea_out_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pipe_en & stg_valid[NSTAGE]),
    .push_blk  (stg_blk[NSTAGE]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_blk   (res_blk),
    .full      (skid_full)
  );

  assign out_tdata = {res_blk.second_word, res_blk.first_word};
  assign out_tlast = res_blk.last_block;

`ifndef SYNTHESIS
  // the skid entry only fills behind a waiting result
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");

  // a held skid entry is not released while the result is not taken
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_tready && !out_tready) |=> !in_tready)
    else $error("skid entry released without an output request");

  // after a stall with the output taken, the pipeline resumes next cycle
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_tready && out_tready) |=> in_tready)
    else $error("pipeline stayed stalled after output request");
`endif

endmodule

// File: rtl/tea_half_stage.sv
// one registered half round of tea, direction chosen by the mode bit
module tea_half_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             second_half,
  input  logic             decrypt,
  input  tea_pkg::key_t    key,
  input  logic [31:0]      enc_sum,
  input  logic [31:0]      dec_sum,
  input  logic             in_valid,
  input  tea_pkg::blk_t    in_blk,
  output logic             out_valid,
  output tea_pkg::blk_t    out_blk
);
  import tea_pkg::*;

  logic        valid_r;
  blk_t        blk_r;
  blk_t        blk_nxt;
  logic        upd_second;
  logic [31:0] src;
  logic [31:0] dst;
  logic [31:0] sum;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] mix;
  logic [31:0] res;

  // encipher updates first then second word, decipher the reverse
  assign upd_second = second_half ^ decrypt;
  assign sum        = decrypt ? dec_sum : enc_sum;
  assign src        = upd_second ? in_blk.first_word : in_blk.second_word;
  assign dst        = upd_second ? in_blk.second_word : in_blk.first_word;
  assign ka         = upd_second ? key.k2 : key.k0;
  assign kb         = upd_second ? key.k3 : key.k1;
  assign mix        = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
  assign res        = decrypt ? (dst - mix) : (dst + mix);

  always_comb begin
    blk_nxt = in_blk;
    if (upd_second) begin
      blk_nxt.second_word = res;
    end else begin
      blk_nxt.first_word = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blk_r <= blk_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_blk   = blk_r;

endmodule

// File: rtl/tea_out_skid.sv
// output register with one skid entry behind it
module tea_out_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tea_pkg::blk_t push_blk,
  input  logic          out_ready,
  output logic          out_valid,
  output tea_pkg::blk_t out_blk,
  output logic          full
);
  import tea_pkg::*;

  logic out_valid_r;
  logic out_valid_nxt;
  blk_t out_blk_r;
  logic skid_valid_r;
  logic skid_valid_nxt;
  blk_t skid_blk_r;
  logic pop;
  logic load_out;
  logic load_skid;
  logic move_skid;

  assign pop = out_valid_r & out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    move_skid      = 1'b0;
    if (skid_valid_r) begin
      // no push can arrive while the skid entry is held
      if (pop) begin
        move_skid      = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_blk_r <= push_blk;
    end else if (move_skid) begin
      out_blk_r <= skid_blk_r;
    end
    if (load_skid) begin
      skid_blk_r <= push_blk;
    end
  end

  assign out_valid = out_valid_r;
  assign out_blk   = out_blk_r;
  assign full      = skid_valid_r;

endmodule

// File: tb/tea_cipher_checker.sv
`timescale 1ns / 1ps
// checker for the tea block cipher: tracks the registers, predicts each block and compares results
module tea_cipher_checker #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] first_word, [63:32] second_word
  input  logic        in_tlast,   // last_block
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // [31:0] out_first_word, [63:32] out_second_word
  input  logic        out_tlast,  // out_last_block
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending_blocks,
  output int          blocks_checked,
  output int          input_stall_cycles
);
  import tea_pkg::*;

  key_t   key_words;
  logic   decipher_on;
  blk_t   expected_blocks[$];
  int     n_fail;
  int     n_checked;
  int     n_stall;

  assign fail_count         = n_fail;
  assign blocks_checked     = n_checked;
  assign input_stall_cycles = n_stall;

  function automatic logic [31:0] round_mix(logic [31:0] x, logic [31:0] sum,
                                            logic [31:0] ka, logic [31:0] kb);
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

  function automatic blk_t tea_transform(blk_t blk, key_t k, logic dec);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    blk_t        res;
    y = blk.first_word;
    z = blk.second_word;
    if (dec) begin
      sum = 32'(TEA_DELTA * 32'(ROUNDS));
      for (int r = 0; r < ROUNDS; r++) begin
        z   = z - round_mix(y, sum, k.k2, k.k3);
        y   = y - round_mix(z, sum, k.k0, k.k1);
        sum = sum - TEA_DELTA;
      end
    end else begin
      sum = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        sum = sum + TEA_DELTA;
        y   = y + round_mix(z, sum, k.k0, k.k1);
        z   = z + round_mix(y, sum, k.k2, k.k3);
      end
    end
    res.first_word  = y;
    res.second_word = z;
    res.last_block  = blk.last_block;
    return res;
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s: expected %h, actual %h", $time, name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    blk_t want;
    blk_t got;
    if (!rst_n) begin
      key_words   = '0;
      decipher_on = 1'b0;
      expected_blocks.delete();
      n_fail      = 0;
      n_checked   = 0;
      n_stall     = 0;
    end else begin
      // register access
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (reg_idx_t'(cfg_paddr[4:2]))
            REG_KEY0: key_words.k0 = cfg_pwdata;
            REG_KEY1: key_words.k1 = cfg_pwdata;
            REG_KEY2: key_words.k2 = cfg_pwdata;
            REG_KEY3: key_words.k3 = cfg_pwdata;
            REG_MODE: decipher_on  = cfg_pwdata[0];
            default: ;
          endcase
        end else begin
          case (reg_idx_t'(cfg_paddr[4:2]))
            REG_KEY0: report_field("key word 0 read", key_words.k0, cfg_prdata);
            REG_KEY1: report_field("key word 1 read", key_words.k1, cfg_prdata);
            REG_KEY2: report_field("key word 2 read", key_words.k2, cfg_prdata);
            REG_KEY3: report_field("key word 3 read", key_words.k3, cfg_prdata);
            REG_MODE: report_field("mode read", {31'b0, decipher_on}, cfg_prdata);
            default: ;
          endcase
        end
      end
      // result side
      if (out_tvalid && out_tready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t ERROR unexpected result: expected none, actual %h/%b",
                   $time, out_tdata, out_tlast);
          n_fail++;
        end else begin
          want = expected_blocks.pop_front();
          got  = {out_tlast, out_tdata};
          report_field("first word", want.first_word, got.first_word);
          report_field("second word", want.second_word, got.second_word);
          report_field("last flag", {31'b0, want.last_block}, {31'b0, got.last_block});
          n_checked++;
        end
      end
      // request side
      if (in_tvalid && in_tready)
        expected_blocks.push_back(tea_transform({in_tlast, in_tdata}, key_words, decipher_on));
      if (in_tvalid && !in_tready)
        n_stall++;
    end
    pending_blocks <= expected_blocks.size();
  end

endmodule

// File: tb/tea_block_cipher_tb.sv
`timescale 1ns / 1ps
// testbench top for the tea block cipher: request and register stimulus, verdict
module tea_block_cipher_tb;
  import tea_pkg::*;

  localparam int unsigned ROUNDS      = 32;
  localparam int unsigned LATENCY     = 2 * ROUNDS + 1;  // request to result through the pipe
  localparam int unsigned HOLD_CYCLES = 300;             // long output stall, well past pipe depth
  localparam int unsigned NUM_PHASES  = 10;
  localparam logic        APB_READ    = 1'b0;
  localparam logic        APB_WRITE   = 1'b1;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_style_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [63:0] in_tdata    = '0;    // [31:0] first_word, [63:32] second_word
  logic        in_tlast    = 1'b0;  // last_block
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;

  logic        in_tready;
  logic        out_tvalid;
  logic [63:0] out_tdata;           // [31:0] out_first_word, [63:32] out_second_word
  logic        out_tlast;           // out_last_block
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending_blocks;
  int blocks_checked;
  int input_stall_cycles;

  int settings_used     = 0;
  bit long_hold_request = 1'b0;  // set by the stimulus, cleared by the receiver
  bit sender_idles      = 1'b1;
  int burst_left        = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tea_block_cipher #(.ROUNDS(ROUNDS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  tea_cipher_checker #(.ROUNDS(ROUNDS)) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .in_tlast          (in_tlast),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tlast         (out_tlast),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready),
    .fail_count        (fail_count),
    .pending_blocks    (pending_blocks),
    .blocks_checked    (blocks_checked),
    .input_stall_cycles(input_stall_cycles)
  );

  // all tasks are entered and left right after a rising edge

  // setup, then access until pready, then idle, so calls can run back to back
  task automatic apb_access(logic write, logic [2:0] idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                          logic [31:0] k3, logic [31:0] mode_word);
    apb_access(APB_WRITE, REG_KEY0, k0);
    apb_access(APB_WRITE, REG_KEY1, k1);
    apb_access(APB_WRITE, REG_KEY2, k2);
    apb_access(APB_WRITE, REG_KEY3, k3);
    apb_access(APB_WRITE, REG_MODE, mode_word);
    settings_used++;
  endtask

  task automatic read_back_regs();
    for (int i = REG_KEY0; i <= REG_MODE; i++)
      apb_access(APB_READ, 3'(i), '0);
  endtask

  // one block request; a nonzero gap first drops tvalid and waits out the gap,
  // otherwise tvalid stays high from the previous request (burst)
  task automatic send_block(logic [31:0] first_word, logic [31:0] second_word,
                            logic last_block, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {second_word, first_word};
    in_tlast  <= last_block;
    do @(posedge clk); while (!in_tready);
  endtask

  // wait until every block in flight has come back, so registers may change
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_blocks != 0) @(posedge clk);
  endtask

  // bursts of random length separated by random gaps
  function automatic int next_gap();
    if (!sender_idles) return 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      return $urandom_range(1, 10);
    end
    burst_left--;
    return 0;
  endfunction

  // data words lean toward the corners: zero, all ones, walking ones and zeros
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'(1) << $urandom_range(0, 31);
      3: return ~(32'(1) << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_key_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // random phase: fresh key and direction, then a run of random blocks
  task automatic run_phase(int count, logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                           logic [31:0] k3, logic dir, bit idles, bit long_hold);
    // junk in the upper mode bits must be masked off by the block
    load_key(k0, k1, k2, k3, ($urandom & ~32'h1) | 32'(dir));
    sender_idles = idles;
    burst_left   = 0;
    if (long_hold) long_hold_request = 1'b1;
    repeat (count) send_block(pick_word(), pick_word(), 1'($urandom_range(0, 1)), next_gap());
    drain();
  endtask

  // receiver: changes its stall style at random over the run; on request it holds
  // off for a long stretch so the pipe fills and the input backs up
  initial begin : output_receiver
    rx_style_t style;
    int        cycle_cnt;
    style     = RX_ALWAYS;
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      cycle_cnt++;
      if (cycle_cnt % 64 == 0) style = rx_style_t'($urandom_range(0, 3));
      case (style)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
        RX_RARELY: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= ((cycle_cnt % 7) < 3);
      endcase
    end
  end

  initial begin : stimulus
    logic [31:0] w0, w1, w2, w3;
    logic        dir;
    int          count;

    // synchronous reset, held low from the start
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: all-zero key, enciphering; registers read back as zero
    read_back_regs();
    send_block('0, '0, 1'b0, 0);
    send_block('1, '1, 1'b1, 0);
    drain();
    settings_used++;

    // all-ones key, mode written with only upper bits set (masked to encipher)
    load_key('1, '1, '1, '1, 32'hFFFF_FFFE);
    read_back_regs();
    send_block('0, '0, 1'b0, 0);
    send_block('1, '1, 1'b1, 0);
    send_block(32'h8000_0000, 32'h0000_0001, 1'b0, 2);
    send_block('1, '0, 1'b1, 0);
    drain();

    // same key, decipher with excess mode bits
    apb_access(APB_WRITE, REG_MODE, 32'h0000_0003);
    settings_used++;
    apb_access(APB_READ, REG_MODE, '0);
    send_block('0, '0, 1'b0, 0);
    send_block('1, '1, 1'b1, 0);
    send_block(32'h0000_0001, 32'h8000_0000, 1'b0, 0);
    send_block('0, '1, 1'b1, 3);
    drain();

    // writes past the register list must change nothing
    for (int i = REG_MODE + 1; i < 8; i++)
      apb_access(APB_WRITE, 3'(i), $urandom);
    read_back_regs();
    send_block(32'h0123_4567, 32'h89AB_CDEF, 1'b0, 0);
    send_block(32'hFEDC_BA98, 32'h7654_3210, 1'b1, 0);
    drain();

    // top and bottom bits of each key word, enciphering
    load_key(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0);
    send_block('0, '0, 1'b1, 0);
    send_block(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0);
    send_block($urandom, $urandom, 1'b1, 1);
    drain();

    // random phases; phase 3 runs flat out against the long output hold,
    // phase 7 has no sender idling, phases 4 and 5 use the key extremes
    for (int p = 0; p < NUM_PHASES; p++) begin
      w0 = pick_key_word();
      w1 = pick_key_word();
      w2 = pick_key_word();
      w3 = pick_key_word();
      if (p == 4) {w0, w1, w2, w3} = '0;
      if (p == 5) {w0, w1, w2, w3} = '1;
      dir   = (p < 2) ? 1'(p) : 1'($urandom_range(0, 1));
      count = (p == 3) ? 200 : $urandom_range(80, 130);
      run_phase(count, w0, w1, w2, w3, dir, (p != 3) && (p != 7), p == 3);
    end

    // nothing more is expected; watch a bit longer for stray results
    repeat (LATENCY + 10) @(posedge clk);

    $display("covered %0d blocks under %0d key and direction settings, both directions",
             blocks_checked, settings_used);
    $display("input backed up for %0d cycles while the output was stalled",
             input_stall_cycles);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard limit, many times the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d blocks still in flight", pending_blocks);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/tea_pkg.sv
rtl/tea_half_stage.sv
rtl/tea_out_skid.sv
rtl/tea_block_cipher.sv
tb/tea_cipher_checker.sv
tb/tea_block_cipher_tb.sv
